// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define PTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/core/pts_pkg.sv -----
// Package for the priority task scheduler: sizes, codes and shared types.
// Depends on nothing.
package pts_pkg;
    localparam int TASK_SLOTS = 16;
    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam int LINK_W = SLOT_W + 1;
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(TASK_SLOTS);
    localparam logic [31:0] WAIT_FOREVER = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        ACT_CREATE = 4'd0, ACT_SET_PRIO = 4'd1, ACT_GET_PRIO = 4'd2,
        ACT_RESUME = 4'd3, ACT_BLOCK = 4'd4, ACT_UNBLOCK = 4'd5,
        ACT_CLOSE = 4'd6, ACT_TICK = 4'd7, ACT_SCHEDULE = 4'd8
    } t_action;

    typedef enum logic [1:0] {
        ST_SUSPENDED = 2'd0, ST_RUNNING = 2'd1, ST_BLOCKED = 2'd2
    } t_task_state;

    typedef enum logic [1:0] {
        STAT_OK = 2'd0, STAT_BAD = 2'd1, STAT_NONE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE, BK_TICK, BK_SCHED, BK_OUT
    } t_bk_state;

    // Classified command passed from front to back.
    typedef struct packed {
        logic [3:0]  action;
        logic [3:0]  slot;
        logic [7:0]  prio;
        logic [31:0] delay;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  task_slot;
        logic [7:0]  prio_out;
        logic [31:0] tick_count;
    } t_res;
endpackage

// ----- rtl/core/pts_stream_if.sv -----
// Valid/ready channel interfaces for the scheduler.
// Depends on nothing.
interface pts_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [3:0]  slot;
    logic [7:0]  prio_in;
    logic [31:0] delay_in;
    modport source (output valid, action, slot, prio_in, delay_in, input ready);
    modport sink (input valid, action, slot, prio_in, delay_in, output ready);
endinterface

interface pts_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  task_slot;
    logic [7:0]  prio_out;
    logic [31:0] tick_count;
    modport source (output valid, status, task_slot, prio_out, tick_count, input ready);
    modport sink (input valid, status, task_slot, prio_out, tick_count, output ready);
endinterface

// ----- rtl/core/pts_front.sv -----
// Front end: accepts command beats into a two-entry queue.
// Depends on pts_pkg and pts_stream_if.
module pts_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pts_cmd_if.sink       cmd,
    output logic          o_valid,
    output pts_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    pts_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push;

    assign cmd.ready = (r_cnt != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign o_valid   = (r_cnt != 2'd0);
    assign o_cmd     = r_q[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{cmd.action, cmd.slot, cmd.prio_in, cmd.delay_in};
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end
endmodule

// ----- rtl/core/pts_back.sv -----
// Back end: task table, list walks for tick and schedule, result register.
// Depends on pts_pkg and pts_stream_if.
module pts_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    input  logic          i_valid,
    input  pts_pkg::t_cmd i_cmd,
    output logic          o_pop,
    pts_res_if.source     res
);
    localparam int N = pts_pkg::TASK_SLOTS;
    localparam int SW = pts_pkg::SLOT_W;
    localparam int LW = pts_pkg::LINK_W;
    localparam logic [LW-1:0] NIL = pts_pkg::NIL_LINK;

    logic [31:0]   r_iwait;
    logic [N-1:0]  r_used;
    logic [1:0]    r_state [N];
    logic [7:0]    r_prio  [N];
    logic [31:0]   r_delay [N];
    logic [LW-1:0] r_next  [N];
    logic [LW-1:0] r_prev  [N];
    logic [LW-1:0] r_head, r_cur, r_t, r_best;
    logic [LW-1:0] r_steps;
    logic [31:0]   r_tick;
    pts_pkg::t_bk_state r_st, n_st;
    pts_pkg::t_res r_res;
    logic [1:0]    n_status;
    logic [7:0]    n_prio_out;

    logic          in_range, used;
    logic [SW-1:0] s, t;
    logic          cur_ok;
    logic [LW-1:0] tn;

    assign s        = i_cmd.slot[SW-1:0];
    assign in_range = ({4'd0, i_cmd.slot} < 8'(N));
    assign used     = in_range && r_used[s];
    assign t        = r_t[SW-1:0];
    assign tn       = r_next[t];
    assign cur_ok   = (r_cur != NIL);
    assign o_pop    = (r_st == pts_pkg::BK_IDLE) && i_valid;

    assign res.valid      = (r_st == pts_pkg::BK_OUT);
    assign res.status     = r_res.status;
    assign res.task_slot  = r_res.task_slot;
    assign res.prio_out   = r_res.prio_out;
    assign res.tick_count = r_tick;

    // Next state of the sequencer.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            pts_pkg::BK_IDLE: begin
                if (i_valid) begin
                    if (i_cmd.action == pts_pkg::ACT_TICK) n_st = pts_pkg::BK_TICK;
                    else if (i_cmd.action == pts_pkg::ACT_SCHEDULE) n_st = pts_pkg::BK_SCHED;
                    else n_st = pts_pkg::BK_OUT;
                end
            end
            pts_pkg::BK_TICK: begin
                if (r_t == NIL || r_steps == LW'(N - 1) || tn == NIL) begin
                    n_st = pts_pkg::BK_OUT;
                end
            end
            pts_pkg::BK_SCHED: begin
                if ((cur_ok && r_t == r_cur) || r_steps == LW'(N - 1)
                    || (tn == NIL && !cur_ok) || r_t == NIL) begin
                    n_st = pts_pkg::BK_OUT;
                end
            end
            pts_pkg::BK_OUT: if (res.ready) n_st = pts_pkg::BK_IDLE;
            default: n_st = pts_pkg::BK_IDLE;
        endcase
    end

    // Status and readback for the actions that need no list walk.
    always_comb begin
        n_status   = pts_pkg::STAT_OK;
        n_prio_out = 8'd0;
        if (i_cmd.action == pts_pkg::ACT_CREATE) begin
            if (!in_range || used) n_status = pts_pkg::STAT_BAD;
        end else if (i_cmd.action > pts_pkg::ACT_SCHEDULE) begin
            n_status = pts_pkg::STAT_BAD;
        end else if (i_cmd.action != pts_pkg::ACT_TICK
                     && i_cmd.action != pts_pkg::ACT_SCHEDULE) begin
            if (!used) n_status = pts_pkg::STAT_BAD;
            else if (i_cmd.action == pts_pkg::ACT_GET_PRIO) n_prio_out = r_prio[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= pts_pkg::BK_IDLE;
        else r_st <= n_st;
    end

    // Task table and walk registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iwait <= pts_pkg::WAIT_FOREVER;
            r_used  <= '0;
            r_head  <= NIL;
            r_cur   <= NIL;
            r_tick  <= 32'd1;
            for (int i = 0; i < N; i++) begin
                r_state[i] <= pts_pkg::ST_SUSPENDED;
                r_next[i]  <= NIL;
                r_prev[i]  <= NIL;
            end
        end else begin
            if (i_cfg_we) r_iwait <= i_cfg_wdata;
            unique case (r_st)
                pts_pkg::BK_IDLE: if (i_valid) begin
                    r_res <= '{n_status, i_cmd.slot, n_prio_out, 32'd0};
                    r_steps <= '0;
                    r_best  <= NIL;
                    // Tick walks from the head; schedule starts after the current task.
                    if (i_cmd.action == pts_pkg::ACT_TICK) begin
                        r_tick <= r_tick + 32'd1;
                        r_t    <= r_head;
                    end else begin
                        r_t    <= (cur_ok && r_next[r_cur[SW-1:0]] != NIL)
                                  ? r_next[r_cur[SW-1:0]] : r_head;
                    end
                    if (n_status == pts_pkg::STAT_OK) begin
                        unique case (i_cmd.action)
                            pts_pkg::ACT_CREATE: begin
                                r_used[s]  <= 1'b1;
                                r_prio[s]  <= i_cmd.prio;
                                r_delay[s] <= 32'd0;
                                r_state[s] <= pts_pkg::ST_RUNNING;
                                r_prev[s]  <= NIL;
                                r_next[s]  <= r_head;
                                if (r_head != NIL) r_prev[r_head[SW-1:0]] <= LW'(s);
                                r_head <= LW'(s);
                            end
                            pts_pkg::ACT_SET_PRIO: r_prio[s] <= i_cmd.prio;
                            pts_pkg::ACT_RESUME:
                                if (r_state[s] == pts_pkg::ST_SUSPENDED)
                                    r_state[s] <= pts_pkg::ST_RUNNING;
                            pts_pkg::ACT_BLOCK: begin
                                r_state[s] <= pts_pkg::ST_BLOCKED;
                                r_delay[s] <= i_cmd.delay;
                            end
                            pts_pkg::ACT_UNBLOCK:
                                if (r_state[s] == pts_pkg::ST_BLOCKED)
                                    r_state[s] <= pts_pkg::ST_RUNNING;
                            pts_pkg::ACT_CLOSE: begin
                                if (r_next[s] != NIL) r_prev[r_next[s][SW-1:0]] <= r_prev[s];
                                if (r_prev[s] != NIL) r_next[r_prev[s][SW-1:0]] <= r_next[s];
                                if (r_head == LW'(s)) r_head <= r_next[s];
                                if (r_cur == LW'(s)) r_cur <= NIL;
                                r_next[s]  <= NIL;
                                r_prev[s]  <= NIL;
                                r_state[s] <= pts_pkg::ST_SUSPENDED;
                                r_used[s]  <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                // One list slot per cycle: count down or wake blocked tasks under the wait limit.
                pts_pkg::BK_TICK: if (r_t != NIL) begin
                    if (r_state[t] == pts_pkg::ST_BLOCKED && r_delay[t] < r_iwait) begin
                        if (r_delay[t] == 32'd0) r_state[t] <= pts_pkg::ST_RUNNING;
                        else r_delay[t] <= r_delay[t] - 32'd1;
                    end
                    r_t     <= tn;
                    r_steps <= r_steps + 1'b1;
                end
                // One list slot per cycle: keep the strictly best running task.
                pts_pkg::BK_SCHED: begin
                    logic [LW-1:0] best;
                    best = r_best;
                    if (r_t != NIL && r_state[t] == pts_pkg::ST_RUNNING
                        && (best == NIL || r_prio[t] > r_prio[best[SW-1:0]])) begin
                        best = r_t;
                    end
                    r_best  <= best;
                    r_t     <= (tn == NIL) ? r_head : tn;
                    r_steps <= r_steps + 1'b1;
                    if (n_st == pts_pkg::BK_OUT) begin
                        if (best == NIL) begin
                            r_res.status    <= pts_pkg::STAT_NONE;
                            r_res.task_slot <= 4'd0;
                        end else begin
                            r_cur           <= best;
                            r_res.task_slot <= 4'(best[SW-1:0]);
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ----- rtl/core/priority_task_scheduler_unit.sv -----
// Top level of the priority task scheduler: front queue plus back engine.
// Depends on pts_pkg, pts_stream_if, pts_front, pts_back, assert_macros.svh.
//
//  channel | dir | payload
//  cmd     | in  | action, slot, prio_in, delay_in
//  res     | out | status, task_slot, prio_out, tick_count
//  cfg     | in  | timeout limit (i_cfg_we, i_cfg_wdata)
//
// Simple actions pass from the command queue to the result register. Tick and
// schedule walk the task list one slot per cycle in the back engine, up to 16
// slots. Reset is synchronous, active low.
// A two-beat command queue accepts while the back engine works or stalls.
`include "assert_macros.svh"
module priority_task_scheduler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    pts_cmd_if.sink     cmd,
    pts_res_if.source   res
);
    logic          q_valid, pop;
    pts_pkg::t_cmd q_cmd;

    pts_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cmd(cmd),
        .o_valid(q_valid), .o_cmd(q_cmd), .i_pop(pop)
    );

    pts_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_valid(q_valid), .i_cmd(q_cmd),
        .o_pop(pop), .res(res)
    );

    `PTS_ASSERT_IMP(a_pop_has_item, i_clk, i_rst_n, pop, q_valid, "pop from empty queue")
    `PTS_ASSERT_NXT(a_pop_no_result, i_clk, i_rst_n, pop, !pop, "back took two beats in a row")
    `PTS_ASSERT_IMP(a_status_range, i_clk, i_rst_n, res.valid, res.status != 2'd3, "bad status code")
endmodule

// ----- tb/priority_task_scheduler_unit_checker.sv -----
`timescale 1ns / 1ps
// Checker for the priority task scheduler: mirrors the task table, predicts each result beat
// and compares it with the beat that the block sends. Depends on pts_pkg and pts_stream_if.
module priority_task_scheduler_unit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    pts_cmd_if          cmd,
    pts_res_if          res,
    output int          o_errors,
    output int          o_pending
);
    localparam int N = pts_pkg::TASK_SLOTS;
    localparam int SW = pts_pkg::SLOT_W;
    localparam int LW = pts_pkg::LINK_W;
    localparam logic [LW-1:0] NIL = pts_pkg::NIL_LINK;

    // Mirror of the task table.
    logic                 used_q [N];
    pts_pkg::t_task_state state_q [N];
    logic [7:0]           prio_q [N];
    logic [31:0]          delay_q [N];
    logic [LW-1:0]        next_q [N];
    logic [LW-1:0]        prev_q [N];
    logic [LW-1:0]        head_q;
    logic [LW-1:0]        cur_q;
    logic [31:0]          ticks_q;
    logic [31:0]          wait_limit_q;

    pts_pkg::t_res sched_results_q[$];

    assign o_pending = sched_results_q.size();

    // Advance the tick counter and, along the list, count down or wake blocked tasks under the wait limit.
    function automatic void sched_tick();
        logic [LW-1:0] t;
        int steps;
        t = head_q;
        steps = 0;
        ticks_q = ticks_q + 32'd1;
        while (t != NIL && steps < N) begin
            if (state_q[t[SW-1:0]] == pts_pkg::ST_BLOCKED
                && delay_q[t[SW-1:0]] < wait_limit_q) begin
                if (delay_q[t[SW-1:0]] == 32'd0)
                    state_q[t[SW-1:0]] = pts_pkg::ST_RUNNING;
                else
                    delay_q[t[SW-1:0]] = delay_q[t[SW-1:0]] - 32'd1;
            end
            t = next_q[t[SW-1:0]];
            steps++;
        end
    endfunction

    // Pick the running task of strictly highest priority, starting after the current one.
    function automatic logic [LW-1:0] sched_pick();
        logic [LW-1:0] best;
        logic [LW-1:0] t;
        best = NIL;
        if (head_q == NIL)
            return NIL;
        if (cur_q != NIL && next_q[cur_q[SW-1:0]] != NIL)
            t = next_q[cur_q[SW-1:0]];
        else
            t = head_q;
        for (int steps = 0; steps < N; steps++) begin
            if (state_q[t[SW-1:0]] == pts_pkg::ST_RUNNING) begin
                if (best == NIL || prio_q[t[SW-1:0]] > prio_q[best[SW-1:0]])
                    best = t;
            end
            if (cur_q != NIL && t == cur_q)
                break;
            t = next_q[t[SW-1:0]];
            if (t == NIL) begin
                if (cur_q == NIL)
                    break;
                t = head_q;
            end
        end
        if (best != NIL)
            cur_q = best;
        return best;
    endfunction

    // Apply one command beat to the mirror and return the result it should produce.
    function automatic pts_pkg::t_res sched_apply(logic [3:0] act, logic [3:0] s,
                                                  logic [7:0] p, logic [31:0] d);
        pts_pkg::t_res r;
        logic [LW-1:0] n;
        logic [LW-1:0] pv;
        logic [LW-1:0] pick;
        r = '0;
        r.status = pts_pkg::STAT_OK;
        r.task_slot = s;
        case (act)
            pts_pkg::ACT_CREATE: begin
                if (used_q[s]) begin
                    r.status = pts_pkg::STAT_BAD;
                end else begin
                    used_q[s] = 1'b1;
                    prio_q[s] = p;
                    delay_q[s] = 32'd0;
                    prev_q[s] = NIL;
                    next_q[s] = head_q;
                    if (head_q != NIL)
                        prev_q[head_q[SW-1:0]] = LW'(s);
                    head_q = LW'(s);
                    state_q[s] = pts_pkg::ST_RUNNING;
                end
            end
            pts_pkg::ACT_SET_PRIO: begin
                if (!used_q[s]) r.status = pts_pkg::STAT_BAD;
                else prio_q[s] = p;
            end
            pts_pkg::ACT_GET_PRIO: begin
                if (!used_q[s]) r.status = pts_pkg::STAT_BAD;
                else r.prio_out = prio_q[s];
            end
            pts_pkg::ACT_RESUME: begin
                if (!used_q[s]) r.status = pts_pkg::STAT_BAD;
                else if (state_q[s] == pts_pkg::ST_SUSPENDED) state_q[s] = pts_pkg::ST_RUNNING;
            end
            pts_pkg::ACT_BLOCK: begin
                if (!used_q[s]) begin
                    r.status = pts_pkg::STAT_BAD;
                end else begin
                    state_q[s] = pts_pkg::ST_BLOCKED;
                    delay_q[s] = d;
                end
            end
            pts_pkg::ACT_UNBLOCK: begin
                if (!used_q[s]) r.status = pts_pkg::STAT_BAD;
                else if (state_q[s] == pts_pkg::ST_BLOCKED) state_q[s] = pts_pkg::ST_RUNNING;
            end
            pts_pkg::ACT_CLOSE: begin
                if (!used_q[s]) begin
                    r.status = pts_pkg::STAT_BAD;
                end else begin
                    n = next_q[s];
                    pv = prev_q[s];
                    if (n != NIL) prev_q[n[SW-1:0]] = pv;
                    if (pv != NIL) next_q[pv[SW-1:0]] = n;
                    if (head_q == LW'(s)) head_q = n;
                    if (cur_q == LW'(s)) cur_q = NIL;
                    next_q[s] = NIL;
                    prev_q[s] = NIL;
                    state_q[s] = pts_pkg::ST_SUSPENDED;
                    used_q[s] = 1'b0;
                end
            end
            pts_pkg::ACT_TICK: sched_tick();
            pts_pkg::ACT_SCHEDULE: begin
                pick = sched_pick();
                if (pick == NIL) begin
                    r.status = pts_pkg::STAT_NONE;
                    r.task_slot = '0;
                end else begin
                    r.task_slot = pick[SW-1:0];
                end
            end
            default: r.status = pts_pkg::STAT_BAD;
        endcase
        r.tick_count = ticks_q;
        return r;
    endfunction

    // Track reset, register writes, command beats and result beats on each rising edge.
    always @(posedge i_clk) begin
        pts_pkg::t_res got;
        pts_pkg::t_res want;
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                used_q[i] = 1'b0;
                state_q[i] = pts_pkg::ST_SUSPENDED;
                prio_q[i] = '0;
                delay_q[i] = '0;
                next_q[i] = NIL;
                prev_q[i] = NIL;
            end
            head_q = NIL;
            cur_q = NIL;
            ticks_q = 32'd1;
            wait_limit_q = pts_pkg::WAIT_FOREVER;
            o_errors = 0;
            sched_results_q.delete();
        end else begin
            if (i_cfg_we)
                wait_limit_q = i_cfg_wdata;
            if (cmd.valid && cmd.ready)
                sched_results_q.push_back(sched_apply(cmd.action, cmd.slot, cmd.prio_in,
                                                      cmd.delay_in));
            if (res.valid && res.ready) begin
                got.status = res.status;
                got.task_slot = res.task_slot;
                got.prio_out = res.prio_out;
                got.tick_count = res.tick_count;
                if (sched_results_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %p", $time, got);
                    o_errors++;
                end else begin
                    want = sched_results_q.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, got.status);
                        o_errors++;
                    end
                    if (got.task_slot !== want.task_slot) begin
                        $display("%0t: task_slot expected %0d actual %0d", $time,
                                 want.task_slot, got.task_slot);
                        o_errors++;
                    end
                    if (got.prio_out !== want.prio_out) begin
                        $display("%0t: prio_out expected %0d actual %0d", $time,
                                 want.prio_out, got.prio_out);
                        o_errors++;
                    end
                    if (got.tick_count !== want.tick_count) begin
                        $display("%0t: tick_count expected %0d actual %0d", $time,
                                 want.tick_count, got.tick_count);
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/priority_task_scheduler_unit_tb.sv -----
`timescale 1ns / 1ps
// Top of the scheduler testbench: clock, reset, command stimulus, result stalls and verdict.
// Depends on pts_pkg, pts_stream_if, the block and priority_task_scheduler_unit_checker.
module priority_task_scheduler_unit_tb;
    localparam int IDLE_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 207;
    localparam int DRAIN_CYCLES = 30;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic [31:0] wait_limit;
    int          errors;
    int          pending;
    int          idle_pct;
    int          stall_pct;
    int          quiet_cycles;

    pts_cmd_if cmd ();
    pts_res_if res ();

    priority_task_scheduler_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .cmd         (cmd.sink),
        .res         (res.source)
    );

    priority_task_scheduler_unit_checker checker_u (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .cmd         (cmd),
        .res         (res),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver stalls are redrawn on every falling edge.
    always @(negedge i_clk) begin
        res.ready = ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: give up when nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("priority_task_scheduler_unit_tb: errors");
            $finish;
        end
    end

    // Send one command beat, with random idle cycles ahead of it.
    task automatic send_cmd(logic [3:0] act, logic [3:0] s, logic [7:0] p, logic [31:0] d);
        while ($urandom_range(99) < idle_pct) begin
            cmd.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd.valid = 1'b1;
        cmd.action = act;
        cmd.slot = s;
        cmd.prio_in = p;
        cmd.delay_in = d;
        @(posedge i_clk);
        while (!cmd.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop sending, let every result drain, then let the engine settle.
    task automatic drain();
        cmd.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_wait_limit(logic [31:0] value);
        i_cfg_we = 1'b1;
        i_cfg_wdata = value;
        wait_limit = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Idling mix of one random phase.
    task automatic set_mix(int phase);
        unique case (phase)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 75; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 75; end
            default: begin idle_pct = 10; stall_pct = 10; end
        endcase
    endtask

    // One random command, weighted toward building and working a task list.
    task automatic send_random();
        int pick;
        logic [3:0] act;
        logic [7:0] p;
        logic [31:0] d;
        pick = $urandom_range(99);
        if (pick < 15) act = pts_pkg::ACT_CREATE;
        else if (pick < 22) act = pts_pkg::ACT_SET_PRIO;
        else if (pick < 29) act = pts_pkg::ACT_GET_PRIO;
        else if (pick < 35) act = pts_pkg::ACT_RESUME;
        else if (pick < 50) act = pts_pkg::ACT_BLOCK;
        else if (pick < 57) act = pts_pkg::ACT_UNBLOCK;
        else if (pick < 64) act = pts_pkg::ACT_CLOSE;
        else if (pick < 82) act = pts_pkg::ACT_TICK;
        else if (pick < 97) act = pts_pkg::ACT_SCHEDULE;
        else act = 4'($urandom_range(15, 9));
        // Small priorities make ties, which exercise the rotation.
        p = ($urandom_range(1) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
        pick = $urandom_range(9);
        if (pick < 6) d = $urandom_range(4);
        else if (pick < 8) d = wait_limit + 32'($urandom_range(2)) - 32'd1;
        else d = $urandom;
        send_cmd(act, 4'($urandom_range(15)), p, d);
    endtask

    initial begin
        cmd.valid = 1'b0;
        cmd.action = pts_pkg::ACT_TICK;
        cmd.slot = '0;
        cmd.prio_in = '0;
        cmd.delay_in = '0;
        res.ready = 1'b1;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        wait_limit = pts_pkg::WAIT_FOREVER;
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty schedule, extremes, rotation, timeouts, closing head and current.
        send_cmd(pts_pkg::ACT_SCHEDULE, 4'd0, 8'd0, 32'd0);
        send_cmd(pts_pkg::ACT_CREATE, 4'd0, 8'd255, 32'd0);
        send_cmd(pts_pkg::ACT_CREATE, 4'd15, 8'd255, 32'hFFFF_FFFF);
        send_cmd(pts_pkg::ACT_CREATE, 4'd0, 8'd1, 32'd0);
        send_cmd(pts_pkg::ACT_SCHEDULE, 4'd0, 8'd0, 32'd0);
        send_cmd(pts_pkg::ACT_SCHEDULE, 4'd0, 8'd0, 32'd0);
        send_cmd(pts_pkg::ACT_SET_PRIO, 4'd15, 8'd0, 32'd0);
        send_cmd(pts_pkg::ACT_GET_PRIO, 4'd15, 8'd0, 32'd0);
        send_cmd(pts_pkg::ACT_GET_PRIO, 4'd5, 8'd0, 32'd0);
        send_cmd(pts_pkg::ACT_RESUME, 4'd0, 8'd0, 32'd0);
        send_cmd(pts_pkg::ACT_BLOCK, 4'd15, 8'd0, 32'd0);
        send_cmd(pts_pkg::ACT_TICK, 4'd0, 8'd0, 32'd0);
        send_cmd(pts_pkg::ACT_BLOCK, 4'd0, 8'd0, 32'd2);
        send_cmd(pts_pkg::ACT_TICK, 4'd0, 8'd0, 32'd0);
        send_cmd(pts_pkg::ACT_SCHEDULE, 4'd0, 8'd0, 32'd0);
        send_cmd(pts_pkg::ACT_UNBLOCK, 4'd0, 8'd0, 32'd0);
        send_cmd(pts_pkg::ACT_BLOCK, 4'd0, 8'd0, 32'hFFFF_FFFF);
        send_cmd(pts_pkg::ACT_TICK, 4'd0, 8'd0, 32'd0);
        send_cmd(pts_pkg::ACT_CLOSE, 4'd15, 8'd0, 32'd0);
        send_cmd(pts_pkg::ACT_SCHEDULE, 4'd0, 8'd0, 32'd0);
        send_cmd(pts_pkg::ACT_CLOSE, 4'd0, 8'd0, 32'd0);
        send_cmd(pts_pkg::ACT_CLOSE, 4'd0, 8'd0, 32'd0);
        send_cmd(pts_pkg::ACT_SCHEDULE, 4'd0, 8'd0, 32'd0);
        send_cmd(4'd9, 4'd3, 8'd0, 32'd0);
        send_cmd(4'd15, 4'd3, 8'd0, 32'd0);

        // Random phases, each under its own timeout setting and idling mix.
        for (int phase = 0; phase < 4; phase++) begin
            set_mix(phase);
            drain();
            unique case (phase)
                0: write_wait_limit(32'd3);
                1: write_wait_limit(32'd1);
                2: write_wait_limit(32'd40);
                default: write_wait_limit(pts_pkg::WAIT_FOREVER);
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Short runs without idling, so gaps do not cover every stretch.
                if (n % 50 >= 25 && n % 50 < 35) begin
                    idle_pct = 0;
                    stall_pct = 0;
                end else begin
                    set_mix(phase);
                end
                send_random();
            end
        end

        drain();
        if (errors == 0)
            $display("priority_task_scheduler_unit_tb: clean");
        else
            $display("priority_task_scheduler_unit_tb: errors");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/pts_pkg.sv
rtl/core/pts_stream_if.sv
rtl/core/pts_front.sv
rtl/core/pts_back.sv
rtl/core/priority_task_scheduler_unit.sv
tb/priority_task_scheduler_unit_checker.sv
tb/priority_task_scheduler_unit_tb.sv
